[src/tsgs_pkg.sv]
// Shared types, constants and helpers for the topic/sentiment Gibbs sampler.
// No dependencies; every other file of the block imports this package.
package tsgs_pkg;

  // Default sizes of the count stores
  localparam int MAX_DOCS_DEF   = 1024;
  localparam int MAX_LABELS_DEF = 4;
  localparam int MAX_TOPICS_DEF = 64;
  localparam int VOCAB_SIZE_DEF = 4096;

  // Register reset values
  localparam logic [2:0]  LABEL_COUNT_RST = 3'd3;
  localparam logic [6:0]  TOPIC_COUNT_RST = 7'd50;
  localparam logic [31:0] ALPHA_RST       = 32'h0001_0000;
  localparam logic [31:0] GAMMA_RST       = 32'h0001_0000;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int LBL_W      = 3;   // label count register width, also label index
  localparam int TOP_W      = 7;   // topic count register width, also topic index
  localparam int DIV_W      = 56;  // divider operand width
  localparam int Q_W        = 32;  // Q8.24 quotient / weight
  localparam int ACC_W      = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LABEL_COUNT = 2'd0,
    CFG_TOPIC_COUNT = 2'd1,
    CFG_ALPHA       = 2'd2,
    CFG_GAMMA       = 2'd3
  } cfg_e;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_RESAMPLE = 2'd1,
    OP_PRIOR    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    DIV_Q1,
    DIV_Q2,
    DIV_Q3
  } div_sel_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_WRAP,
    S_CHECK,
    S_PRI_RD,
    S_PRI_WR,
    S_CNT_RD,
    S_CNT_WR,
    S_LAB_RD,
    S_Q3_GO,
    S_Q3_WAIT,
    S_PAIR_RD,
    S_Q1_GO,
    S_Q1_WAIT,
    S_Q2_GO,
    S_Q2_WAIT,
    S_MUL_A,
    S_MUL_B,
    S_ACC,
    S_THR,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [9:0]  doc_index;
    logic [11:0] word_id;
    logic [1:0]  label_in;
    logic [5:0]  topic_in;
    logic [15:0] random_fraction;
    logic [31:0] prior_weight;
  } item_t;

  typedef struct packed {
    logic [1:0] label_out;
    logic [5:0] topic_out;
    logic       status;
  } result_t;

  typedef struct packed {
    logic     clear;
    logic     load;
    logic     wrap;
    logic     check;
    logic     cnt_up;
    logic     cnt_wr;
    logic     pri_wr;
    logic     loop_addr;
    logic     loop_init;
    logic     loop_step;
    logic     acc_init;
    logic     div_start;
    div_sel_e div_sel;
    logic     q1_ld;
    logic     q2_ld;
    logic     q3_ld;
    logic     mul_a;
    logic     mul_b;
    logic     acc_add;
    logic     thr_ld;
    logic     take_hit;
    logic     take_last;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       wrapped;
    logic       bad;
    logic [1:0] op;
    logic       last_k;
    logic       last_l;
    logic       div_done;
    logic       scan_hit;
  } sts_t;

  // Q8.24 product truncation with saturation
  function automatic logic [Q_W-1:0] q24_sat(input logic [63:0] p);
    logic [Q_W-1:0] r;
    if (p[63:56] != 8'd0) r = '1;
    else r = p[55:24];
    return r;
  endfunction

endpackage

[src/tsgs_div.sv]
// Iterative Q8.24 divider: one quotient bit per cycle, saturating.
// Depends on tsgs_pkg.
module tsgs_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [tsgs_pkg::DIV_W-1:0] num_i,
  input  logic [tsgs_pkg::DIV_W-1:0] den_i,
  output logic                     done_o,
  output logic [tsgs_pkg::Q_W-1:0] quo_o
);
  import tsgs_pkg::*;

  localparam int CNT_W = $clog2(Q_W);

  logic [DIV_W-1:0] rem_q, den_q;
  logic [Q_W-1:0]   sh_q, quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q, done_q;
  logic [DIV_W:0]   rem_sh;
  logic             ge;
  logic             ovf;

  assign rem_sh = {rem_q, sh_q[Q_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  // integer part of 256 or more saturates
  assign ovf    = {8'd0, num_i} >= {den_i, 8'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (den_i == '0 || ovf) begin
          done_q <= 1'b1;
          run_q  <= 1'b0;
        end else begin
          run_q <= 1'b1;
        end
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(Q_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= num_i >> 8;
      sh_q  <= {num_i[7:0], 24'd0};
      if (den_i == '0) quo_q <= '0;
      else if (ovf) quo_q <= '1;
      else quo_q <= '0;
    end else if (run_q) begin
      rem_q <= ge ? DIV_W'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_W-1:0];
      sh_q  <= {sh_q[Q_W-2:0], 1'b0};
      quo_q <= {quo_q[Q_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[src/tsgs_dp.sv]
// Datapath: config registers, count memories, divider, multiplier, accumulator.
// Depends on tsgs_pkg and tsgs_div.
module tsgs_dp #(
  parameter int MAX_DOCS   = tsgs_pkg::MAX_DOCS_DEF,
  parameter int MAX_LABELS = tsgs_pkg::MAX_LABELS_DEF,
  parameter int MAX_TOPICS = tsgs_pkg::MAX_TOPICS_DEF,
  parameter int VOCAB_SIZE = tsgs_pkg::VOCAB_SIZE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tsgs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tsgs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  tsgs_pkg::item_t               item_i,
  input  tsgs_pkg::cmd_t                cmd_i,
  output tsgs_pkg::sts_t                sts_o,
  output tsgs_pkg::result_t             result_o
);
  import tsgs_pkg::*;

  localparam int DOC_DEPTH = MAX_DOCS;
  localparam int DL_DEPTH  = MAX_DOCS * MAX_LABELS;
  localparam int DLZ_DEPTH = MAX_DOCS * MAX_LABELS * MAX_TOPICS;
  localparam int LZ_DEPTH  = MAX_LABELS * MAX_TOPICS;
  localparam int LZW_DEPTH = MAX_LABELS * MAX_TOPICS * VOCAB_SIZE;
  localparam int PR_DEPTH  = MAX_LABELS * VOCAB_SIZE;
  localparam int CLR_DEPTH = (DLZ_DEPTH > LZW_DEPTH) ? DLZ_DEPTH : LZW_DEPTH;

  localparam int DOC_AW = (DOC_DEPTH > 1) ? $clog2(DOC_DEPTH) : 1;
  localparam int DL_AW  = (DL_DEPTH > 1) ? $clog2(DL_DEPTH) : 1;
  localparam int DLZ_AW = (DLZ_DEPTH > 1) ? $clog2(DLZ_DEPTH) : 1;
  localparam int LZ_AW  = (LZ_DEPTH > 1) ? $clog2(LZ_DEPTH) : 1;
  localparam int LZW_AW = (LZW_DEPTH > 1) ? $clog2(LZW_DEPTH) : 1;
  localparam int PR_AW  = (PR_DEPTH > 1) ? $clog2(PR_DEPTH) : 1;
  localparam int LI_W   = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
  localparam int CLR_W  = $clog2(CLR_DEPTH);

  // configuration
  logic [LBL_W-1:0] label_count_q;
  logic [TOP_W-1:0] topic_count_q;
  logic [31:0]      alpha_q, gamma_q;
  logic [LBL_W-1:0] nl;
  logic [TOP_W-1:0] nt;

  // item
  logic [1:0]       op_q;
  logic [9:0]       d_q;
  logic [11:0]      w_q;
  logic [LBL_W-1:0] lab_q;
  logic [TOP_W-1:0] top_q;
  logic [15:0]      rf_q;
  logic [31:0]      pw_q;
  logic             status_q;

  // loop and sums
  logic [LBL_W-1:0] l_q, l_sel;
  logic [TOP_W-1:0] k_q, k_sel;
  logic [38:0]      asum_q;
  logic [34:0]      gsum_q;
  logic [ACC_W-1:0] sum_q [MAX_LABELS];
  logic [ACC_W-1:0] sum_rd;
  logic [CLR_W-1:0] clr_q;

  // memories and read registers
  logic [15:0]      doc_mem [DOC_DEPTH];
  logic [15:0]      dl_mem  [DL_DEPTH];
  logic [15:0]      dlz_mem [DLZ_DEPTH];
  logic [23:0]      lz_mem  [LZ_DEPTH];
  logic [23:0]      lzw_mem [LZW_DEPTH];
  logic [31:0]      pr_mem  [PR_DEPTH];
  logic [ACC_W-1:0] run_mem [LZ_DEPTH];
  logic [15:0]      doc_rd_q, dl_rd_q, dlz_rd_q;
  logic [23:0]      lz_rd_q, lzw_rd_q;
  logic [31:0]      pr_rd_q;
  logic [ACC_W-1:0] run_rd_q;

  logic [DOC_AW-1:0] doc_a;
  logic [DL_AW-1:0]  dl_a;
  logic [DLZ_AW-1:0] dlz_a;
  logic [LZ_AW-1:0]  lz_a;
  logic [LZW_AW-1:0] lzw_a;
  logic [PR_AW-1:0]  pr_a;

  // arithmetic
  logic [DIV_W-1:0] div_num, div_den;
  logic             div_done;
  logic [Q_W-1:0]   div_quo;
  logic [Q_W-1:0]   q1_q, q2_q, q3_q;
  logic [63:0]      prod_q;
  logic [ACC_W-1:0] acc_q, acc_sum, thr_q;
  logic             bad;

  always_comb begin
    if (label_count_q == '0) nl = LBL_W'(1);
    else if (int'(label_count_q) > MAX_LABELS) nl = LBL_W'(MAX_LABELS);
    else nl = label_count_q;
    if (topic_count_q == '0) nt = TOP_W'(1);
    else if (int'(topic_count_q) > MAX_TOPICS) nt = TOP_W'(MAX_TOPICS);
    else nt = topic_count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_count_q <= LABEL_COUNT_RST;
      topic_count_q <= TOPIC_COUNT_RST;
      alpha_q       <= ALPHA_RST;
      gamma_q       <= GAMMA_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_LABEL_COUNT: label_count_q <= cfg_wdata_i[LBL_W-1:0];
        CFG_TOPIC_COUNT: topic_count_q <= cfg_wdata_i[TOP_W-1:0];
        CFG_ALPHA:       alpha_q       <= cfg_wdata_i;
        CFG_GAMMA:       gamma_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // item capture, index wrap, result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= item_i.operation;
      d_q   <= item_i.doc_index;
      w_q   <= item_i.word_id;
      lab_q <= LBL_W'(item_i.label_in);
      top_q <= TOP_W'(item_i.topic_in);
      rf_q  <= item_i.random_fraction;
      pw_q  <= item_i.prior_weight;
    end else if (cmd_i.take_hit) begin
      lab_q <= l_q;
      top_q <= k_q;
    end else if (cmd_i.take_last) begin
      lab_q <= nl - 1'b1;
      top_q <= nt - 1'b1;
    end
    if (cmd_i.wrap) begin
      if (int'(d_q) >= MAX_DOCS) d_q <= d_q - 10'(MAX_DOCS);
      if (int'(w_q) >= VOCAB_SIZE) w_q <= w_q - 12'(VOCAB_SIZE);
      asum_q <= 39'(nt) * 39'(alpha_q);
      gsum_q <= 35'(nl) * 35'(gamma_q);
    end
    if (cmd_i.check) status_q <= bad;
  end

  assign bad = (op_q != OP_ADD && op_q != OP_RESAMPLE && op_q != OP_PRIOR)
               || (lab_q >= nl)
               || (op_q != OP_PRIOR && top_q >= nt);

  // label/topic walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_q <= '0;
      k_q <= '0;
    end else if (cmd_i.loop_init) begin
      l_q <= '0;
      k_q <= '0;
    end else if (cmd_i.loop_step) begin
      if (k_q == nt - 1'b1) begin
        k_q <= '0;
        l_q <= l_q + 1'b1;
      end else begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  assign l_sel = cmd_i.loop_addr ? l_q : lab_q;
  assign k_sel = cmd_i.loop_addr ? k_q : top_q;

  assign doc_a = DOC_AW'(d_q);
  assign dl_a  = DL_AW'(int'(d_q) * MAX_LABELS + int'(l_sel));
  assign dlz_a = DLZ_AW'((int'(d_q) * MAX_LABELS + int'(l_sel)) * MAX_TOPICS + int'(k_sel));
  assign lz_a  = LZ_AW'(int'(l_sel) * MAX_TOPICS + int'(k_sel));
  assign lzw_a = LZW_AW'((int'(l_sel) * MAX_TOPICS + int'(k_sel)) * VOCAB_SIZE + int'(w_q));
  assign pr_a  = PR_AW'(int'(l_sel) * VOCAB_SIZE + int'(w_q));

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clear) clr_q <= clr_q + 1'b1;
  end

  // count memories: read-modify-write, one step up or down
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      if (int'(clr_q) < DOC_DEPTH) doc_mem[clr_q[DOC_AW-1:0]] <= '0;
    end else if (cmd_i.cnt_wr) begin
      doc_mem[doc_a] <= cmd_i.cnt_up ? doc_rd_q + 16'd1 : doc_rd_q - 16'd1;
    end
    doc_rd_q <= doc_mem[doc_a];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      if (int'(clr_q) < DL_DEPTH) dl_mem[clr_q[DL_AW-1:0]] <= '0;
    end else if (cmd_i.cnt_wr) begin
      dl_mem[dl_a] <= cmd_i.cnt_up ? dl_rd_q + 16'd1 : dl_rd_q - 16'd1;
    end
    dl_rd_q <= dl_mem[dl_a];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      if (int'(clr_q) < DLZ_DEPTH) dlz_mem[clr_q[DLZ_AW-1:0]] <= '0;
    end else if (cmd_i.cnt_wr) begin
      dlz_mem[dlz_a] <= cmd_i.cnt_up ? dlz_rd_q + 16'd1 : dlz_rd_q - 16'd1;
    end
    dlz_rd_q <= dlz_mem[dlz_a];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      if (int'(clr_q) < LZ_DEPTH) lz_mem[clr_q[LZ_AW-1:0]] <= '0;
    end else if (cmd_i.cnt_wr) begin
      lz_mem[lz_a] <= cmd_i.cnt_up ? lz_rd_q + 24'd1 : lz_rd_q - 24'd1;
    end
    lz_rd_q <= lz_mem[lz_a];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      if (int'(clr_q) < LZW_DEPTH) lzw_mem[clr_q[LZW_AW-1:0]] <= '0;
    end else if (cmd_i.cnt_wr) begin
      lzw_mem[lzw_a] <= cmd_i.cnt_up ? lzw_rd_q + 24'd1 : lzw_rd_q - 24'd1;
    end
    lzw_rd_q <= lzw_mem[lzw_a];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      if (int'(clr_q) < PR_DEPTH) pr_mem[clr_q[PR_AW-1:0]] <= '0;
    end else if (cmd_i.pri_wr) begin
      pr_mem[pr_a] <= pw_q;
    end
    pr_rd_q <= pr_mem[pr_a];
  end

  // running sums of the current resample, no clear needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_add) run_mem[lz_a] <= acc_sum;
    run_rd_q <= run_mem[lz_a];
  end

  // per-label beta sums
  assign sum_rd = sum_q[LI_W'(l_sel)];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LABELS; i++) sum_q[i] <= '0;
    end else if (cmd_i.pri_wr) begin
      sum_q[LI_W'(l_sel)] <= sum_rd - ACC_W'(pr_rd_q) + ACC_W'(pw_q);
    end
  end

  // divider operands
  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_Q1: begin
        div_num = DIV_W'({lzw_rd_q, 16'd0}) + DIV_W'(pr_rd_q);
        div_den = DIV_W'({lz_rd_q, 16'd0}) + DIV_W'(sum_rd);
      end
      DIV_Q2: begin
        div_num = DIV_W'({dlz_rd_q, 16'd0}) + DIV_W'(alpha_q);
        div_den = DIV_W'({dl_rd_q, 16'd0}) + DIV_W'(asum_q);
      end
      DIV_Q3: begin
        div_num = DIV_W'({dl_rd_q, 16'd0}) + DIV_W'(gamma_q);
        div_den = DIV_W'({doc_rd_q, 16'd0}) + DIV_W'(gsum_q);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  tsgs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // weight product, accumulation, draw threshold
  assign acc_sum = acc_q + ACC_W'(q24_sat(prod_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.q1_ld) q1_q <= div_quo;
    if (cmd_i.q2_ld) q2_q <= div_quo;
    if (cmd_i.q3_ld) q3_q <= div_quo;
    if (cmd_i.mul_a) prod_q <= 64'(q1_q) * 64'(q2_q);
    else if (cmd_i.mul_b) prod_q <= 64'(q24_sat(prod_q)) * 64'(q3_q);
    if (cmd_i.acc_init) acc_q <= '0;
    else if (cmd_i.acc_add) acc_q <= acc_sum;
    if (cmd_i.thr_ld) thr_q <= ACC_W'((64'(acc_q) * 64'(rf_q)) >> 16);
  end

  always_comb begin
    sts_o.clr_last = int'(clr_q) == CLR_DEPTH - 1;
    sts_o.wrapped  = int'(d_q) < MAX_DOCS && int'(w_q) < VOCAB_SIZE;
    sts_o.bad      = bad;
    sts_o.op       = op_q;
    sts_o.last_k   = k_q == nt - 1'b1;
    sts_o.last_l   = l_q == nl - 1'b1;
    sts_o.div_done = div_done;
    sts_o.scan_hit = run_rd_q > thr_q;
  end

  assign result_o.label_out = lab_q[1:0];
  assign result_o.topic_out = top_q[5:0];
  assign result_o.status    = status_q;

endmodule

[src/tsgs_ctrl.sv]
// Sequencer for the sampler: clear pass, count updates, weight walk, draw.
// Depends on tsgs_pkg.
module tsgs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  tsgs_pkg::sts_t sts_i,
  output tsgs_pkg::cmd_t cmd_o,
  output logic           busy_o,
  output logic           result_valid_o
);
  import tsgs_pkg::*;

  state_e state_q, state_d;
  logic   up_q, up_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      up_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      up_q    <= up_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    up_d    = up_q;
    unique case (state_q)
      S_CLEAR:   if (sts_i.clr_last) state_d = S_IDLE;
      S_IDLE:    if (start_i) state_d = S_WRAP;
      S_WRAP:    if (sts_i.wrapped) state_d = S_CHECK;
      S_CHECK: begin
        up_d = (sts_i.op == OP_ADD);
        priority if (sts_i.bad) state_d = S_DONE;
        else if (sts_i.op == OP_PRIOR) state_d = S_PRI_RD;
        else state_d = S_CNT_RD;
      end
      S_PRI_RD:  state_d = S_PRI_WR;
      S_PRI_WR:  state_d = S_DONE;
      S_CNT_RD:  state_d = S_CNT_WR;
      S_CNT_WR:  state_d = up_q ? S_DONE : S_LAB_RD;
      S_LAB_RD:  state_d = S_Q3_GO;
      S_Q3_GO:   state_d = S_Q3_WAIT;
      S_Q3_WAIT: if (sts_i.div_done) state_d = S_PAIR_RD;
      S_PAIR_RD: state_d = S_Q1_GO;
      S_Q1_GO:   state_d = S_Q1_WAIT;
      S_Q1_WAIT: if (sts_i.div_done) state_d = S_Q2_GO;
      S_Q2_GO:   state_d = S_Q2_WAIT;
      S_Q2_WAIT: if (sts_i.div_done) state_d = S_MUL_A;
      S_MUL_A:   state_d = S_MUL_B;
      S_MUL_B:   state_d = S_ACC;
      S_ACC: begin
        priority if (sts_i.last_k && sts_i.last_l) state_d = S_THR;
        else if (sts_i.last_k) state_d = S_LAB_RD;
        else state_d = S_PAIR_RD;
      end
      S_THR:     state_d = S_SCAN_RD;
      S_SCAN_RD: state_d = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (sts_i.scan_hit || (sts_i.last_k && sts_i.last_l)) begin
          state_d = S_CNT_RD;
          up_d    = 1'b1;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_DONE:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.loop_addr = 1'b1;
    cmd_o.cnt_up    = up_q;
    cmd_o.div_sel   = DIV_Q1;
    unique case (state_q)
      S_CLEAR:   cmd_o.clear = 1'b1;
      S_IDLE:    cmd_o.load = start_i;
      S_WRAP:    cmd_o.wrap = 1'b1;
      S_CHECK:   cmd_o.check = 1'b1;
      S_PRI_RD:  cmd_o.loop_addr = 1'b0;
      S_PRI_WR: begin
        cmd_o.loop_addr = 1'b0;
        cmd_o.pri_wr    = 1'b1;
      end
      S_CNT_RD:  cmd_o.loop_addr = 1'b0;
      S_CNT_WR: begin
        cmd_o.loop_addr = 1'b0;
        cmd_o.cnt_wr    = 1'b1;
        cmd_o.loop_init = !up_q;
        cmd_o.acc_init  = !up_q;
      end
      S_LAB_RD:  ;
      S_Q3_GO: begin
        cmd_o.div_sel   = DIV_Q3;
        cmd_o.div_start = 1'b1;
      end
      S_Q3_WAIT: cmd_o.q3_ld = sts_i.div_done;
      S_PAIR_RD: ;
      S_Q1_GO: begin
        cmd_o.div_sel   = DIV_Q1;
        cmd_o.div_start = 1'b1;
      end
      S_Q1_WAIT: cmd_o.q1_ld = sts_i.div_done;
      S_Q2_GO: begin
        cmd_o.div_sel   = DIV_Q2;
        cmd_o.div_start = 1'b1;
      end
      S_Q2_WAIT: cmd_o.q2_ld = sts_i.div_done;
      S_MUL_A:   cmd_o.mul_a = 1'b1;
      S_MUL_B:   cmd_o.mul_b = 1'b1;
      S_ACC: begin
        cmd_o.acc_add   = 1'b1;
        cmd_o.loop_step = !(sts_i.last_k && sts_i.last_l);
      end
      S_THR: begin
        cmd_o.thr_ld    = 1'b1;
        cmd_o.loop_init = 1'b1;
      end
      S_SCAN_RD: ;
      S_SCAN_CMP: begin
        cmd_o.take_hit  = sts_i.scan_hit;
        cmd_o.take_last = !sts_i.scan_hit && sts_i.last_k && sts_i.last_l;
        cmd_o.loop_step = !sts_i.scan_hit && !(sts_i.last_k && sts_i.last_l);
      end
      S_DONE:    ;
      default:   ;
    endcase
  end

  assign busy_o         = state_q != S_IDLE;
  assign result_valid_o = state_q == S_DONE;

  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |=> state_q == S_IDLE)
    else $error("result strobe longer than one cycle");

  a_accept_goes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> state_q == S_WRAP)
    else $error("accepted item not taken up");

  a_div_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_Q1_WAIT || state_q == S_Q2_WAIT ||
                        state_q == S_Q3_WAIT))
    else $error("quotient finished outside a wait state");

endmodule

[src/topic_sentiment_gibbs_sampler.sv]
// Top level of the joint sentiment-topic Gibbs sampler.
// Depends on tsgs_pkg, tsgs_ctrl, tsgs_dp (which holds tsgs_div).
//
//   channel   | ports                                   | handshake
//   ----------+-----------------------------------------+---------------------------
//   item in   | start_i, busy_o, item_i                 | taken when start_i & !busy_o
//   result    | result_valid_o, result_o                | one-cycle strobe, no stall
//   config    | cfg_we_i, cfg_index_i, cfg_wdata_i      | write when cfg_we_i, no wait
//
// Sequence: after reset a clearing pass zeroes every count store, one entry per
// cycle, over max(MAX_DOCS*MAX_LABELS*MAX_TOPICS, MAX_LABELS*MAX_TOPICS*VOCAB_SIZE)
// entries (1,048,576 at the defaults); busy_o is high meanwhile. From acceptance
// to the strobe, an item passes S_WRAP, which repeats while MAX_DOCS or VOCAB_SIZE
// is wrapped off an index, then S_CHECK; add_token goes on through S_CNT_RD and
// S_CNT_WR, load_prior through S_PRI_RD and S_PRI_WR, to S_DONE, and an ignored
// item straight to S_DONE. resample_token uses the one shared divider for two
// quotients per label/topic pair and one per label, then scans the pairs to draw.
// Results cannot be stalled; the strobe lasts one cycle and busy_o drops after it.
module topic_sentiment_gibbs_sampler #(
  parameter int MAX_DOCS   = tsgs_pkg::MAX_DOCS_DEF,
  parameter int MAX_LABELS = tsgs_pkg::MAX_LABELS_DEF,
  parameter int MAX_TOPICS = tsgs_pkg::MAX_TOPICS_DEF,
  parameter int VOCAB_SIZE = tsgs_pkg::VOCAB_SIZE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  tsgs_pkg::item_t               item_i,
  output logic                          result_valid_o,
  output tsgs_pkg::result_t             result_o,
  input  logic                          cfg_we_i,
  input  logic [tsgs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tsgs_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import tsgs_pkg::*;

  // controller to datapath commands and the status coming back
  cmd_t cmd;
  sts_t sts;

  tsgs_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o)
  );

  // count stores, config registers and the weight arithmetic
  tsgs_dp #(
    .MAX_DOCS   (MAX_DOCS),
    .MAX_LABELS (MAX_LABELS),
    .MAX_TOPICS (MAX_TOPICS),
    .VOCAB_SIZE (VOCAB_SIZE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .result_o    (result_o)
  );

endmodule
